@@ hdl/fbtp_pkg.sv @@
// ----------------------------------------------------------------------------
// fbtp_pkg
// Shared constants, font tables and controller/datapath bundles for the
// monochrome framebuffer text plotter.
// ----------------------------------------------------------------------------
package fbtp_pkg;

  localparam int ROWS          = 64;
  localparam int COLUMNS       = 128;
  localparam int MAX_SCALE     = 8;
  localparam int BYTES_PER_ROW = COLUMNS / 8;
  localparam int ADDR_W        = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int BYTE_W        = $clog2(BYTES_PER_ROW);
  localparam int CW            = 11;

  typedef logic signed [CW-1:0] coord_t;

  localparam logic [2:0] MODE_PLOT   = 3'd0;
  localparam logic [2:0] MODE_CHAR   = 3'd1;
  localparam logic [2:0] MODE_HALO   = 3'd2;
  localparam logic [2:0] MODE_BAND   = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;
  localparam logic [2:0] MODE_INVALL = 3'd5;
  localparam logic [2:0] MODE_READ   = 3'd6;
  localparam logic [2:0] MODE_NOP    = 3'd7;

  // five glyph rows, three bits each, top row in the high octal digit
  localparam logic [14:0] DIGIT_FONT [10] = '{
    15'o75557, 15'o26227, 15'o71747, 15'o71717, 15'o55711,
    15'o74717, 15'o74757, 15'o71122, 15'o75757, 15'o75717
  };

  localparam logic [14:0] LETTER_FONT [26] = '{
    15'o25755, 15'o65656, 15'o34443, 15'o65556, 15'o74747,
    15'o74744, 15'o34553, 15'o55755, 15'o72227, 15'o11152,
    15'o55655, 15'o44447, 15'o57755, 15'o65555, 15'o75557,
    15'o75744, 15'o75571, 15'o75655, 15'o34216, 15'o72222,
    15'o55557, 15'o55552, 15'o55775, 15'o55255, 15'o55222,
    15'o71247
  };

  localparam logic [14:0] BANG_GLYPH  = 15'o22202;
  localparam logic [14:0] COLON_GLYPH = 15'o02020;

  function automatic logic [14:0] glyph_bits(input logic [7:0] code);
    logic [14:0] g;
    g = 15'o0;
    if (code >= 8'h30 && code <= 8'h39) begin
      g = DIGIT_FONT[4'(code - 8'h30)];
    end else if (code >= 8'h41 && code <= 8'h5a) begin
      g = LETTER_FONT[5'(code - 8'h41)];
    end else if (code >= 8'h61 && code <= 8'h7a) begin
      g = LETTER_FONT[5'(code - 8'h61)];
    end else if (code == 8'h21) begin
      g = BANG_GLYPH;
    end else if (code == 8'h3a) begin
      g = COLON_GLYPH;
    end
    return g;
  endfunction

  typedef struct packed {
    logic load;
    logic setup;
    logic cols;
    logic rd;
    logic mask;
    logic wr;
    logic init_wr;
    logic out_load;
    logic out_next;
  } fbtp_cmd_t;

  typedef struct packed {
    logic empty;
    logic row_last;
    logic is_read;
    logic out_last;
  } fbtp_stat_t;

endpackage

@@ hdl/fbtp_ctrl.sv @@
// ----------------------------------------------------------------------------
// fbtp_ctrl
// Sequencer: clearing pass, item setup, per-row read-modify-write, row readout.
// ----------------------------------------------------------------------------
module fbtp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  fbtp_pkg::fbtp_stat_t st,
  output fbtp_pkg::fbtp_cmd_t  cmd
);
  import fbtp_pkg::*;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_COLS  = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_MASK  = 3'd5;
  localparam logic [2:0] S_WRITE = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (st.row_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = st.empty ? S_IDLE : S_COLS;
      end
      S_COLS: begin
        cmd.cols   = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_MASK;
      end
      S_MASK: begin
        if (st.is_read) begin
          cmd.out_load = 1'b1;
          state_next   = S_EMIT;
        end else begin
          cmd.mask   = 1'b1;
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.wr     = 1'b1;
        state_next = st.row_last ? S_IDLE : S_READ;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.out_next = 1'b1;
          if (st.out_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ hdl/fbtp_datapath.sv @@
// ----------------------------------------------------------------------------
// fbtp_datapath
// Frame store (one 128-bit word per row), glyph/column masks, row update
// and the readout buffer.
// ----------------------------------------------------------------------------
module fbtp_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  fbtp_pkg::fbtp_cmd_t       cmd,
  output fbtp_pkg::fbtp_stat_t      st,
  input  logic [2:0]                mode,
  input  logic signed [8:0]         x_pos,
  input  logic signed [8:0]         y_pos,
  input  logic signed [8:0]         band_last,
  input  logic                      pixel_on,
  input  logic [7:0]                char_code,
  input  logic [3:0]                scale,
  output logic [7:0]                row_byte,
  output logic [fbtp_pkg::BYTE_W-1:0] byte_index,
  output logic                      last_byte
);
  import fbtp_pkg::*;

  logic [COLUMNS-1:0] mem [ROWS];

  logic [2:0]   md;
  coord_t       xr, yr, lr;
  logic         on_r;
  logic [14:0]  gly;
  logic [3:0]   sr;
  logic [3:0]   hs;
  coord_t       t, t_end;
  coord_t       rlo [5];
  coord_t       cl [3];
  logic [COLUMNS-1:0] colin [3];
  logic [COLUMNS-1:0] colh [3];
  logic [2:0]   vt, vn;
  logic [COLUMNS-1:0] rdata;
  logic [COLUMNS-1:0] set_m, clr_m, flip_m;
  logic [COLUMNS-1:0] set_m_next, clr_m_next, flip_m_next;
  logic [BYTES_PER_ROW-1:0][7:0] obuf;
  logic [BYTE_W-1:0] k;

  logic         row_ok;
  coord_t       band_lo, band_hi, t_start, t_stop;
  logic [2:0]   vb_m, vb_0, vb_p;
  logic [COLUMNS-1:0] m_t, m_halo, wdata;
  logic [ADDR_W-1:0]  addr;

  assign row_ok = (t >= coord_t'(0)) && (t <= coord_t'(ROWS - 1));
  assign addr   = t[ADDR_W-1:0];

  // band limits and row span of the item
  always_comb begin
    band_lo = (yr < coord_t'(0)) ? coord_t'(0) : yr;
    band_hi = (lr > coord_t'(ROWS - 1)) ? coord_t'(ROWS - 1) : lr;
    t_start = yr;
    t_stop  = yr;
    case (md)
      MODE_CHAR: t_stop = yr + coord_t'({sr, 2'b00}) + coord_t'(sr) - coord_t'(1);
      MODE_HALO: begin
        t_start = yr - coord_t'(1);
        t_stop  = yr + coord_t'({sr, 2'b00}) + coord_t'(sr);
      end
      MODE_BAND: begin
        t_start = band_lo;
        t_stop  = band_hi;
      end
      MODE_CLEAR, MODE_INVALL: begin
        t_start = coord_t'(0);
        t_stop  = coord_t'(ROWS - 1);
      end
      default: ;
    endcase
  end

  always_comb begin
    st.empty    = (md == MODE_NOP) ||
                  ((md == MODE_CHAR || md == MODE_HALO) && sr == 4'd0) ||
                  (md == MODE_BAND && band_lo > band_hi);
    st.row_last = (t == t_end);
    st.is_read  = (md == MODE_READ);
    st.out_last = (k == BYTE_W'(BYTES_PER_ROW - 1));
  end

  // glyph row bits seen at rows t-1, t, t+1
  always_comb begin
    coord_t dm, d0, dp;
    vb_m = 3'b000;
    vb_0 = 3'b000;
    vb_p = 3'b000;
    for (int r = 0; r < 5; r++) begin
      dm = t - coord_t'(1) - rlo[r];
      d0 = t - rlo[r];
      dp = t + coord_t'(1) - rlo[r];
      if (!dm[CW-1] && dm < coord_t'(sr)) vb_m = vb_m | gly[14-3*r -: 3];
      if (!d0[CW-1] && d0 < coord_t'(sr)) vb_0 = vb_0 | gly[14-3*r -: 3];
      if (!dp[CW-1] && dp < coord_t'(sr)) vb_p = vb_p | gly[14-3*r -: 3];
    end
  end

  // word bit w holds column COLUMNS-1-w
  // halo columns come from the widened spans, so glyph pixels just off the
  // frame still erase their on-frame neighbors
  always_comb begin
    m_t    = '0;
    m_halo = '0;
    for (int c = 0; c < 3; c++) begin
      if (vt[2-c]) m_t = m_t | colin[c];
      if (vn[2-c]) m_halo = m_halo | colh[c];
    end
    wdata  = ((rdata & ~clr_m) | set_m) ^ flip_m;
  end

  always_comb begin
    set_m_next  = '0;
    clr_m_next  = '0;
    flip_m_next = '0;
    case (md)
      MODE_PLOT, MODE_CHAR: begin
        if (on_r) set_m_next = m_t;
        else clr_m_next = m_t;
      end
      MODE_HALO: begin
        set_m_next = m_t;
        clr_m_next = m_halo;
      end
      MODE_BAND, MODE_INVALL: flip_m_next = '1;
      MODE_CLEAR: clr_m_next = '1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      md   <= mode;
      xr   <= coord_t'(x_pos);
      yr   <= coord_t'(y_pos);
      lr   <= coord_t'(band_last);
      on_r <= pixel_on;
      gly  <= glyph_bits(char_code);
      sr   <= ({1'b0, scale} > 5'(MAX_SCALE)) ? 4'(MAX_SCALE) : scale;
    end
    if (cmd.setup) begin
      hs <= (md == MODE_PLOT) ? 4'd1 : sr;
      for (int r = 0; r < 5; r++) rlo[r] <= yr + coord_t'(r) * coord_t'(sr);
      for (int c = 0; c < 3; c++) cl[c] <= xr + coord_t'(c) * coord_t'(sr);
    end
    if (cmd.cols) begin
      for (int c = 0; c < 3; c++) begin
        for (int w = 0; w < COLUMNS; w++) begin
          colin[c][w] <= ((coord_t'(COLUMNS - 1 - w) - cl[c]) >= coord_t'(0)) &&
                         ((coord_t'(COLUMNS - 1 - w) - cl[c]) < coord_t'(hs));
          colh[c][w]  <= ((coord_t'(COLUMNS - 1 - w) - cl[c]) >= coord_t'(-1)) &&
                         ((coord_t'(COLUMNS - 1 - w) - cl[c]) <= coord_t'(hs));
        end
      end
    end
    if (cmd.rd) begin
      vt <= (md == MODE_PLOT) ? 3'b100 : vb_0;
      vn <= vb_m | vb_0 | vb_p;
    end
    if (cmd.mask) begin
      set_m  <= set_m_next;
      clr_m  <= clr_m_next;
      flip_m <= flip_m_next;
    end
    if (cmd.out_load) obuf <= row_ok ? rdata : '0;
  end

  // row counter and readout byte counter
  always_ff @(posedge clk) begin
    if (rst) begin
      t     <= coord_t'(0);
      t_end <= coord_t'(ROWS - 1);
      k     <= '0;
    end else begin
      if (cmd.setup) begin
        t     <= t_start;
        t_end <= t_stop;
      end else if (cmd.wr || cmd.init_wr) begin
        t <= t + coord_t'(1);
      end
      if (cmd.out_load) k <= '0;
      else if (cmd.out_next) k <= k + BYTE_W'(1);
    end
  end

  // frame store, one row word per entry
  always_ff @(posedge clk) begin
    if (cmd.init_wr) begin
      mem[addr] <= '0;
    end else if (cmd.wr && row_ok) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) rdata <= mem[addr];
  end

  assign row_byte   = obuf[BYTE_W'(BYTES_PER_ROW - 1) - k];
  assign byte_index = k;
  assign last_byte  = (k == BYTE_W'(BYTES_PER_ROW - 1));

endmodule

@@ hdl/mono_framebuffer_text_plotter_unit.sv @@
// ----------------------------------------------------------------------------
// mono_framebuffer_text_plotter_unit
// 1-bit framebuffer with pixel plot, scaled 3x5 text, band/full invert,
// clear and row readout.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  in      | in_valid / in_stall | mode x_pos y_pos band_last pixel_on
//          |                     | char_code scale
//  out     | out_valid/out_stall | row_byte byte_index last_byte
//
// one item at a time; every touched row costs a read, mask and write step
// on the single-port row memory, plus setup steps per item
// plot: 1 row; char: 5*scale rows; halo char: 5*scale+2 rows;
// band/clear/invert all: the rows covered; read row: 16 output bytes
// after reset a clearing pass over all ROWS rows runs with in_stall high
// out_stall holds the current byte; no new item is taken until the row is out
module mono_framebuffer_text_plotter_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  mode,
  input  logic signed [8:0]           x_pos,
  input  logic signed [8:0]           y_pos,
  input  logic signed [8:0]           band_last,
  input  logic                        pixel_on,
  input  logic [7:0]                  char_code,
  input  logic [3:0]                  scale,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  row_byte,
  output logic [fbtp_pkg::BYTE_W-1:0] byte_index,
  output logic                        last_byte
);
  import fbtp_pkg::*;

  fbtp_cmd_t  cmd;
  fbtp_stat_t st;

  fbtp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  fbtp_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .mode       (mode),
    .x_pos      (x_pos),
    .y_pos      (y_pos),
    .band_last  (band_last),
    .pixel_on   (pixel_on),
    .char_code  (char_code),
    .scale      (scale),
    .row_byte   (row_byte),
    .byte_index (byte_index),
    .last_byte  (last_byte)
  );

`ifndef SYNTHESIS
  a_no_take_while_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("item taken during row readout");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("ready right after item");

  a_row_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_byte) |=> !out_valid)
    else $error("readout ran past last byte");
`endif

endmodule

@@ tb/sv/tb_mono_framebuffer_text_plotter_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mono_framebuffer_text_plotter_unit
// Drives directed and random drawing commands and row reads into the plotter,
// keeps a shadow frame store in a scoreboard and checks every read-back byte.
// ----------------------------------------------------------------------------
module tb_mono_framebuffer_text_plotter_unit;
  import fbtp_pkg::*;

  localparam int LIMIT = 1500000;

  typedef struct packed {
    logic [2:0] mode;
    logic signed [8:0] x;
    logic signed [8:0] y;
    logic signed [8:0] last;
    logic on;
    logic [7:0] code;
    logic [3:0] scale;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] idx;
    logic       lst;
  } rbyte_t;

  class frame_scoreboard;
    logic [7:0] shadow [ROWS*BYTES_PER_ROW];
    rbyte_t pending [$];
    int errors;

    function new();
      foreach (shadow[k]) shadow[k] = 8'h00;
      errors = 0;
    endfunction

    function void set_px(int x, int y, bit on);
      int idx;
      if (x < 0 || x >= COLUMNS || y < 0 || y >= ROWS) return;
      idx = y * BYTES_PER_ROW + x / 8;
      if (on) shadow[idx] |= (8'h80 >> (x % 8));
      else shadow[idx] &= ~(8'h80 >> (x % 8));
    endfunction

    function logic [14:0] font(logic [7:0] c);
      logic [14:0] g;
      g = '0;
      if (c >= "0" && c <= "9") g = DIGIT_FONT[c - "0"];
      else if (c >= "A" && c <= "Z") g = LETTER_FONT[c - "A"];
      else if (c >= "a" && c <= "z") g = LETTER_FONT[c - "a"];
      else if (c == "!") g = BANG_GLYPH;
      else if (c == ":") g = COLON_GLYPH;
      return g;
    endfunction

    function void stamp(int x, int y, logic [14:0] g, int s, bit on);
      for (int r = 0; r < 5; r++)
        for (int c = 0; c < 3; c++)
          if (g[14 - r*3 - c])
            for (int j = 0; j < s; j++)
              for (int i = 0; i < s; i++) set_px(x + c*s + i, y + r*s + j, on);
    endfunction

    function void note_cmd(cmd_t cm);
      int x, y, l, s;
      logic [14:0] g;
      rbyte_t rb;
      x = cm.x; y = cm.y; l = cm.last;
      s = (cm.scale > MAX_SCALE) ? MAX_SCALE : cm.scale;
      g = font(cm.code);
      case (cm.mode)
        MODE_PLOT: set_px(x, y, cm.on);
        MODE_CHAR: stamp(x, y, g, s, cm.on);
        MODE_HALO: begin
          for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++)
              if (dx != 0 || dy != 0) stamp(x + dx, y + dy, g, s, 1'b0);
          stamp(x, y, g, s, 1'b1);
        end
        MODE_BAND: begin
          if (y < 0) y = 0;
          if (l > ROWS - 1) l = ROWS - 1;
          for (int r = y; r <= l; r++)
            for (int b = 0; b < BYTES_PER_ROW; b++)
              shadow[r*BYTES_PER_ROW + b] = ~shadow[r*BYTES_PER_ROW + b];
        end
        MODE_CLEAR: foreach (shadow[k]) shadow[k] = 8'h00;
        MODE_INVALL: foreach (shadow[k]) shadow[k] = ~shadow[k];
        MODE_READ: begin
          for (int k = 0; k < BYTES_PER_ROW; k++) begin
            rb.data = (y >= 0 && y < ROWS) ? shadow[y*BYTES_PER_ROW + k] : 8'h00;
            rb.idx = 4'(k);
            rb.lst = (k == BYTES_PER_ROW - 1);
            pending.push_back(rb);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_byte(rbyte_t got);
      rbyte_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected byte %h idx %0d", got.data, got.idx);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp data %h idx %0d last %b, got %h %0d %b",
                   want.data, want.idx, want.lst, got.data, got.idx, got.lst);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0;
  logic [2:0] mode = 0;
  logic signed [8:0] x_pos = 0, y_pos = 0, band_last = 0;
  logic pixel_on = 0;
  logic [7:0] char_code = 0;
  logic [3:0] scale = 0;
  wire in_stall, out_valid, last_byte;
  wire [7:0] row_byte;
  wire [BYTE_W-1:0] byte_index;

  frame_scoreboard sb = new();
  int cycles = 0;

  always #5 clk = ~clk;

  mono_framebuffer_text_plotter_unit dut (.*);

  // receiver stall pattern and result checking
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
    if (!rst && out_valid && !out_stall)
      sb.check_byte(rbyte_t'{row_byte, byte_index, last_byte});
  end

  int stall_mode = 0;
  always @(negedge clk) begin
    if (cycles % 700 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ((cycles / 5) % 3 == 0);
    endcase
  end

  int burst_left = 0;

  // valid stays up through a burst; it drops only in a gap
  task automatic send(cmd_t cm);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    mode <= cm.mode; x_pos <= cm.x; y_pos <= cm.y; band_last <= cm.last;
    pixel_on <= cm.on; char_code <= cm.code; scale <= cm.scale;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_cmd(cm);
    @(negedge clk);
  endtask

  task automatic send_read(int row);
    cmd_t cm;
    cm = '0;
    cm.mode = MODE_READ;
    cm.y = 9'(row);
    send(cm);
  endtask

  function automatic cmd_t rand_cmd();
    cmd_t cm;
    int p;
    cm.x = 9'($urandom); cm.y = 9'($urandom); cm.last = 9'($urandom);
    cm.on = 1'($urandom); cm.code = 8'($urandom);
    cm.scale = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
    p = $urandom_range(0, 99);
    if (p < 20) begin
      cm.mode = MODE_PLOT;
      if (p < 16) begin
        cm.x = 9'($urandom_range(0, 127)); cm.y = 9'($urandom_range(0, 63));
      end
    end else if (p < 45) begin
      cm.mode = (p < 33) ? MODE_CHAR : MODE_HALO;
      if (p % 3) begin
        cm.x = 9'($urandom_range(0, 140) - 10); cm.y = 9'($urandom_range(0, 70) - 6);
      end
      if (p % 2) cm.code = 8'("0" + $urandom_range(0, 74));
    end else if (p < 52) begin
      cm.mode = MODE_BAND;
      if (p < 50) begin
        cm.y = 9'($urandom_range(0, 70) - 4); cm.last = 9'($urandom_range(0, 70) - 4);
      end
    end else if (p < 54) cm.mode = MODE_CLEAR;
    else if (p < 57) cm.mode = MODE_INVALL;
    else if (p < 59) cm.mode = MODE_NOP;
    else begin
      cm.mode = MODE_READ;
      if (p < 96) cm.y = 9'($urandom_range(0, 63));
    end
    return cm;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0 && cycles < LIMIT) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    cmd_t cm;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed corners
    cm = '0;
    cm.mode = MODE_PLOT; cm.on = 1;
    cm.x = 0; cm.y = 0; send(cm);
    cm.x = 127; cm.y = 63; send(cm);
    cm.x = 128; cm.y = 5; send(cm);
    cm.x = -256; cm.y = -1; send(cm);
    cm.x = 255; cm.y = 255; send(cm);
    send_read(0); send_read(63); send_read(-256); send_read(255); send_read(64);
    cm = '0; cm.mode = MODE_CHAR; cm.on = 1; cm.code = "A"; cm.scale = 1;
    cm.x = 4; cm.y = 2; send(cm);
    cm.code = "z"; cm.scale = 15; cm.x = 100; cm.y = 30; send(cm);
    cm.code = "!"; cm.scale = 0; send(cm);
    cm = '0; cm.mode = MODE_HALO; cm.code = ":"; cm.scale = 2; cm.x = -2; cm.y = 10; send(cm);
    cm.code = 8'hff; cm.scale = 3; cm.x = 20; cm.y = 20; send(cm);
    cm.code = "9"; cm.scale = 8; cm.on = 1; send(cm);
    send_read(20); send_read(30); send_read(3);
    cm = '0; cm.mode = MODE_BAND; cm.y = -256; cm.last = 255; send(cm);
    cm.y = 10; cm.last = 5; send(cm);
    cm.y = 8; cm.last = 12; send(cm);
    send_read(10);
    cm = '0; cm.mode = MODE_INVALL; send(cm);
    cm.mode = MODE_NOP; cm.x = 9'h0ff; cm.y = -1; cm.last = -1; cm.code = 8'hff;
    cm.on = 1; cm.scale = 4'hf; send(cm);
    send_read(1);
    cm = '0; cm.mode = MODE_CLEAR; send(cm);
    send_read(2);

    // full pause: let every byte come out before continuing
    wait_drained();

    for (int n = 0; n < 150; n++) begin
      send(rand_cmd());
      if (n == 75) wait_drained();
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hdl/fbtp_pkg.sv
hdl/fbtp_ctrl.sv
hdl/fbtp_datapath.sv
hdl/mono_framebuffer_text_plotter_unit.sv
tb/sv/tb_mono_framebuffer_text_plotter_unit.sv
